### rtl/core/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// shared constants, types and arithmetic helpers of the dither core
// ----------------------------------------------------------------------------
package fsd_pkg;

   // line store geometry
   localparam int MAX_WIDTH  = 2048;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);

   // error values: signed, ten integer bits and FRAC_BITS fraction bits
   localparam int FRAC_BITS  = 4;
   localparam int ERR_W      = 10 + FRAC_BITS;
   localparam int SUM_W      = ERR_W + 2;
   localparam int PROD_W     = ERR_W + 6;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam err_type ERR_HI = err_type'((2 ** (ERR_W - 1)) - 1);
   localparam err_type ERR_LO = err_type'(-(2 ** (ERR_W - 1)));

   // pixel levels in error format
   localparam err_type THRESH_Q = err_type'(128 * (2 ** FRAC_BITS));
   localparam err_type WHITE_Q  = err_type'(255 * (2 ** FRAC_BITS));

   // diffusion weights, in sixteenths
   localparam int WEIGHT_SHIFT = 4;
   localparam logic [4:0] W_RIGHT       = 5'd7;
   localparam logic [4:0] W_BELOW_LEFT  = 5'd3;
   localparam logic [4:0] W_BELOW       = 5'd5;
   localparam logic [4:0] W_BELOW_RIGHT = 5'd1;

   // luma weights, 16-bit fixed point
   localparam int LUMA_W = 24;
   localparam logic [15:0] LUMA_R = 16'd19595;
   localparam logic [15:0] LUMA_G = 16'd38470;
   localparam logic [15:0] LUMA_B = 16'd7471;

   // register fields
   localparam int IMG_WIDTH_W  = 12;
   localparam int IMG_HEIGHT_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_INPUT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd3;

   localparam logic [1:0] MODE_GRAY   = 2'd0;
   localparam logic [1:0] MODE_THRESH = 2'd1;
   localparam logic [1:0] MODE_DITHER = 2'd2;

   localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

   // clamp a grown sum back into the error range
   function automatic err_type sat_err(input sum_type v);
      err_type r;
      if (v > sum_type'(ERR_HI)) begin
         r = ERR_HI;
      end else if (v < sum_type'(ERR_LO)) begin
         r = ERR_LO;
      end else begin
         r = err_type'(v);
      end
      return r;
   endfunction

   // error times weight over sixteen, truncated toward zero
   function automatic err_type diffuse(input err_type e, input logic [4:0] k);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(e) * $signed({1'b0, k});
      if (p < 0) begin
         p = p + $signed(PROD_W'((2 ** WEIGHT_SHIFT) - 1));
      end
      return err_type'(p >>> WEIGHT_SHIFT);
   endfunction

endpackage

### rtl/core/floyd_steinberg_dither_core.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_core
// path: an accepted item passes the input register, then the result register, to the rsp side
// throughput: one item per clock while rsp_stall is low, set by the line store
//    read-modify-write (read at accept, write while the item is processed)
// reset: synchronous; registers to mode 2, rgb, 640 x 480, error state and
//    position cleared; the line store is not cleared (row 0 never reads it)
// ----------------------------------------------------------------------------
module floyd_steinberg_dither_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_red_or_gray,
   input  logic [7:0]                             req_green,
   input  logic [7:0]                             req_blue,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_pixel_out,
   output logic                                   rsp_row_end,
   output logic                                   rsp_image_end,
   // register writes
   input  logic                                   csr_wr_en,
   input  logic [fsd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [fsd_pkg::CSR_DATA_W-1:0]         csr_wr_data
);

   localparam int AW = fsd_pkg::ADDR_W;

   // ---------------------------------------------------------------- config
   logic [1:0]                          mode_ff;
   logic                                color_ff;
   logic [fsd_pkg::IMG_WIDTH_W-1:0]     width_ff;
   logic [fsd_pkg::IMG_HEIGHT_W-1:0]    height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= fsd_pkg::MODE_DITHER;
         color_ff  <= 1'b1;
         width_ff  <= fsd_pkg::WIDTH_RESET;
         height_ff <= fsd_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fsd_pkg::CSR_MODE:         mode_ff   <= csr_wr_data[1:0];
            fsd_pkg::CSR_COLOR_INPUT:  color_ff  <= csr_wr_data[0];
            fsd_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data[fsd_pkg::IMG_WIDTH_W-1:0];
            fsd_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data[fsd_pkg::IMG_HEIGHT_W-1:0];
            default:                   mode_ff   <= mode_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff;
   logic out_valid_ff;
   logic s1_adv;
   logic req_accept;

   // item in the input register moves on when the result register is free
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------- position
   logic [AW-1:0]                       column_count_ff;
   logic [fsd_pkg::IMG_HEIGHT_W-1:0]    row_count_ff;
   logic [fsd_pkg::IMG_WIDTH_W-1:0]     width_eff;
   logic [AW-1:0]                       col_last;
   logic [fsd_pkg::IMG_HEIGHT_W-1:0]    row_last;
   logic [AW-1:0]                       s0_col;
   logic                                s0_last_col;
   logic                                s0_last_row;

   always_comb begin
      // zero width acts as one, oversize width as the line store size
      if (width_ff == '0) begin
         width_eff = fsd_pkg::IMG_WIDTH_W'(1);
      end else if (width_ff > fsd_pkg::IMG_WIDTH_W'(fsd_pkg::MAX_WIDTH)) begin
         width_eff = fsd_pkg::IMG_WIDTH_W'(fsd_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      col_last = AW'(width_eff - fsd_pkg::IMG_WIDTH_W'(1));
      row_last = (height_ff == '0) ? '0 : height_ff - fsd_pkg::IMG_HEIGHT_W'(1);
      // counters past the end (registers changed mid-image) close the row
      s0_last_col = column_count_ff >= col_last;
      s0_last_row = row_count_ff >= row_last;
      s0_col      = (column_count_ff > col_last) ? col_last : column_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (req_accept) begin
         if (s0_last_col) begin
            column_count_ff <= '0;
            row_count_ff    <= s0_last_row ? '0
                                           : row_count_ff + fsd_pkg::IMG_HEIGHT_W'(1);
         end else begin
            column_count_ff <= column_count_ff + AW'(1);
         end
      end
   end

   // ---------------------------------------------------------------- luma
   logic [fsd_pkg::LUMA_W-1:0] luma_sum;
   logic [7:0]                 s0_gray;

   assign luma_sum =
        fsd_pkg::LUMA_W'(req_red_or_gray) * fsd_pkg::LUMA_W'(fsd_pkg::LUMA_R)
      + fsd_pkg::LUMA_W'(req_green)       * fsd_pkg::LUMA_W'(fsd_pkg::LUMA_G)
      + fsd_pkg::LUMA_W'(req_blue)        * fsd_pkg::LUMA_W'(fsd_pkg::LUMA_B);
   assign s0_gray = color_ff ? luma_sum[fsd_pkg::LUMA_W-1:fsd_pkg::LUMA_W-8]
                             : req_red_or_gray;

   // ---------------------------------------------------------------- input register
   logic [7:0]    s1_gray_ff;
   logic [AW-1:0] s1_col_ff;
   logic          s1_last_col_ff;
   logic          s1_last_row_ff;
   logic          s1_row_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_gray_ff     <= s0_gray;
         s1_col_ff      <= s0_col;
         s1_last_col_ff <= s0_last_col;
         s1_last_row_ff <= s0_last_row;
         s1_row_nz_ff   <= row_count_ff != '0;
      end
   end

   // ---------------------------------------------------------------- line store
   // one write port, one registered read port; the read for an item is issued
   // when it is accepted; writes to that address that land in the same cycle,
   // or that are held as the end-of-row entry, are forwarded
   fsd_pkg::err_type line_mem [fsd_pkg::MAX_WIDTH];
   fsd_pkg::err_type mem_rd_ff;
   logic             fwd_hit_ff;
   fsd_pkg::err_type fwd_data_ff;

   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   fsd_pkg::err_type mem_wd;

   // the end-of-row entry is held in a register before it is written: the next
   // item is column 0, which writes nothing, so the port is free for that write
   logic             pend_valid_ff;
   logic [AW-1:0]    pend_addr_ff;
   fsd_pkg::err_type pend_data_ff;

   // writes requested by the item being processed
   logic             wl_en;
   fsd_pkg::err_type wl_data;
   logic             wc_en;
   fsd_pkg::err_type wc_data;

   always_comb begin
      if (pend_valid_ff) begin
         mem_we = 1'b1;
         mem_wa = pend_addr_ff;
         mem_wd = pend_data_ff;
      end else begin
         mem_we = s1_adv && wl_en;
         mem_wa = s1_col_ff - AW'(1);
         mem_wd = wl_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_wa] <= mem_wd;
      end
      if (req_accept) begin
         mem_rd_ff <= line_mem[s0_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= s1_adv && wc_en;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && wc_en) begin
         pend_addr_ff <= s1_col_ff;
         pend_data_ff <= wc_data;
      end
   end

   // newest write wins: end-of-row entry, then the port
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (s1_adv && wc_en && (s1_col_ff == s0_col)) begin
            fwd_hit_ff  <= 1'b1;
            fwd_data_ff <= wc_data;
         end else if (mem_we && (mem_wa == s0_col)) begin
            fwd_hit_ff  <= 1'b1;
            fwd_data_ff <= mem_wd;
         end else begin
            fwd_hit_ff  <= 1'b0;
            fwd_data_ff <= mem_wd;
         end
      end
   end

   // ---------------------------------------------------------------- diffusion
   fsd_pkg::err_type right_carry_ff;
   fsd_pkg::err_type below_ff;
   fsd_pkg::err_type below_right_ff;

   logic             dither;
   fsd_pkg::err_type above;
   fsd_pkg::err_type with_carry;
   fsd_pkg::err_type old_val;
   fsd_pkg::err_type err;
   fsd_pkg::err_type t_right;
   fsd_pkg::err_type t_below_left;
   fsd_pkg::err_type t_below;
   fsd_pkg::err_type t_below_right;
   fsd_pkg::err_type below_new;
   fsd_pkg::sum_type gray_q;
   logic             white;
   logic [7:0]       pix;

   always_comb begin
      // mode 3 behaves as mode 2
      dither = mode_ff[1];

      // first row sees no error from above
      if (!s1_row_nz_ff) begin
         above = '0;
      end else if (fwd_hit_ff) begin
         above = fwd_data_ff;
      end else begin
         above = mem_rd_ff;
      end

      gray_q     = fsd_pkg::sum_type'({s1_gray_ff, {fsd_pkg::FRAC_BITS{1'b0}}});
      with_carry = fsd_pkg::sat_err(gray_q + fsd_pkg::sum_type'(right_carry_ff));
      old_val    = fsd_pkg::sat_err(fsd_pkg::sum_type'(with_carry)
                                    + fsd_pkg::sum_type'(above));
      white      = old_val >= fsd_pkg::THRESH_Q;
      err        = white ? old_val - fsd_pkg::WHITE_Q : old_val;

      t_right       = fsd_pkg::diffuse(err, fsd_pkg::W_RIGHT);
      t_below_left  = fsd_pkg::diffuse(err, fsd_pkg::W_BELOW_LEFT);
      t_below       = fsd_pkg::diffuse(err, fsd_pkg::W_BELOW);
      t_below_right = fsd_pkg::diffuse(err, fsd_pkg::W_BELOW_RIGHT);

      below_new = fsd_pkg::sat_err(fsd_pkg::sum_type'(below_right_ff)
                                   + fsd_pkg::sum_type'(t_below));

      // below-left entry is complete once this pixel adds its share
      wl_en   = dither && !s1_last_row_ff && (s1_col_ff != '0);
      wl_data = fsd_pkg::sat_err(fsd_pkg::sum_type'(below_ff)
                                 + fsd_pkg::sum_type'(t_below_left));
      // at the row end the entry below is complete as well
      wc_en   = dither && !s1_last_row_ff && s1_last_col_ff;
      wc_data = below_new;

      if (mode_ff == fsd_pkg::MODE_GRAY) begin
         pix = s1_gray_ff;
      end else if (mode_ff == fsd_pkg::MODE_THRESH) begin
         pix = s1_gray_ff[7] ? 8'd255 : 8'd0;
      end else begin
         pix = white ? 8'd255 : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_carry_ff <= '0;
         below_ff       <= '0;
         below_right_ff <= '0;
      end else if (s1_adv) begin
         if (s1_last_col_ff) begin
            // every mode starts a row with no carried error
            right_carry_ff <= '0;
            below_ff       <= '0;
            below_right_ff <= '0;
         end else if (dither) begin
            right_carry_ff <= t_right;
            below_ff       <= below_new;
            below_right_ff <= t_below_right;
         end
      end
   end

   // ---------------------------------------------------------------- result register
   logic [7:0] out_pixel_ff;
   logic       out_row_end_ff;
   logic       out_image_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_pixel_ff     <= pix;
         out_row_end_ff   <= s1_last_col_ff;
         out_image_end_ff <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_image_end = out_image_end_ff;

endmodule

### dv/floyd_steinberg_dither_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_core_test
// drives pixels through the dither core under random backpressure and checks
// every output pixel against a cycle-free predictor of gray conversion,
// thresholding and error diffusion kept in step with every register write
// ----------------------------------------------------------------------------
module floyd_steinberg_dither_core_test;

   // mode code with no name of its own, decoded like dither
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // generous cap on the whole run, in ns
   localparam int WATCHDOG_NS = 12 * 600_000;
   // random items before the idle-free finish
   localparam int RANDOM_ITEMS = 1280;
   localparam int CALM_AFTER   = 1100;
   // widest random image; the fill row covers every entry it can reach
   localparam int FILL_WIDTH   = 300;

   typedef struct packed {
      logic [7:0] level;
      logic       row_end;
      logic       image_end;
   } pixel_result_type;

   // --------------------------------------------------------------------
   // predictor and expected pixel store
   // --------------------------------------------------------------------
   class dither_scoreboard;
      logic [1:0]                       mode_q;
      logic                             rgb_q;
      logic [fsd_pkg::IMG_WIDTH_W-1:0]  width_q;
      logic [fsd_pkg::IMG_HEIGHT_W-1:0] height_q;
      fsd_pkg::err_type                 line_err [fsd_pkg::MAX_WIDTH];
      fsd_pkg::err_type                 carry_right;
      fsd_pkg::err_type                 part_below;
      fsd_pkg::err_type                 part_below_right;
      logic [fsd_pkg::ADDR_W-1:0]       col_pos;
      logic [15:0]                      row_pos;
      pixel_result_type                 pending [$];
      int                               faults;
      int                               checked;

      function new();
         mode_q           = fsd_pkg::MODE_DITHER;
         rgb_q            = 1'b1;
         width_q          = fsd_pkg::WIDTH_RESET;
         height_q         = fsd_pkg::HEIGHT_RESET;
         carry_right      = '0;
         part_below       = '0;
         part_below_right = '0;
         col_pos          = '0;
         row_pos          = '0;
         faults           = 0;
         checked          = 0;
         foreach (line_err[i]) line_err[i] = '0;
      endfunction

      function void flag(string what);
         faults++;
         if (faults <= 10) $display("mismatch: %s", what);
      endfunction

      function int clamp_err(int v);
         if (v > int'(fsd_pkg::ERR_HI)) return int'(fsd_pkg::ERR_HI);
         if (v < int'(fsd_pkg::ERR_LO)) return int'(fsd_pkg::ERR_LO);
         return v;
      endfunction

      // weighted share of an error in sixteenths, truncated toward zero
      function int weigh(int e, int k);
         return (e * k) / 16;
      endfunction

      function void write_reg(logic [fsd_pkg::CSR_INDEX_W-1:0] idx,
                              logic [fsd_pkg::CSR_DATA_W-1:0]  data);
         case (idx)
            fsd_pkg::CSR_MODE:         mode_q   = data[1:0];
            fsd_pkg::CSR_COLOR_INPUT:  rgb_q    = data[0];
            fsd_pkg::CSR_IMAGE_WIDTH:  width_q  = data[fsd_pkg::IMG_WIDTH_W-1:0];
            fsd_pkg::CSR_IMAGE_HEIGHT: height_q = data;
            default: ;
         endcase
      endfunction

      // one accepted pixel: advance the model and queue its output
      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int w, h, c, lum, above, acc, target, err;
         bit last_c, last_r;
         pixel_result_type o;
         w = int'(width_q);
         if (w == 0) w = 1;
         if (w > fsd_pkg::MAX_WIDTH) w = fsd_pkg::MAX_WIDTH;
         h = (height_q == 0) ? 1 : int'(height_q);
         c = (int'(col_pos) >= w) ? w - 1 : int'(col_pos);
         last_c = int'(col_pos) >= w - 1;
         last_r = int'(row_pos) >= h - 1;
         if (rgb_q)
            lum = (int'(fsd_pkg::LUMA_R) * int'(r) + int'(fsd_pkg::LUMA_G) * int'(g)
                   + int'(fsd_pkg::LUMA_B) * int'(b)) >> 16;
         else
            lum = int'(r);

         case (mode_q)
            fsd_pkg::MODE_GRAY:   o.level = 8'(lum);
            fsd_pkg::MODE_THRESH: o.level = (lum < 128) ? 8'd0 : 8'd255;
            default: begin
               above  = (row_pos > 0) ? int'(line_err[c]) : 0;
               acc    = clamp_err(clamp_err((lum << fsd_pkg::FRAC_BITS)
                                            + int'(carry_right)) + above);
               target = (acc < int'(fsd_pkg::THRESH_Q)) ? 0 : int'(fsd_pkg::WHITE_Q);
               err    = acc - target;
               o.level = (target != 0) ? 8'd255 : 8'd0;
               carry_right = last_c ? '0 : fsd_pkg::err_type'(clamp_err(weigh(err, 7)));
               if (!last_r && c > 0)
                  line_err[c-1] = fsd_pkg::err_type'(clamp_err(int'(part_below)
                                                               + weigh(err, 3)));
               part_below = fsd_pkg::err_type'(clamp_err(int'(part_below_right)
                                                         + weigh(err, 5)));
               part_below_right = last_c ? '0 : fsd_pkg::err_type'(weigh(err, 1));
               if (!last_r && last_c) line_err[c] = part_below;
            end
         endcase

         o.row_end   = last_c;
         o.image_end = last_c && last_r;
         pending.push_back(o);

         // every row end clears the carried errors, whatever the mode
         if (last_c) begin
            carry_right      = '0;
            part_below       = '0;
            part_below_right = '0;
            col_pos          = '0;
            row_pos          = last_r ? 16'd0 : row_pos + 16'd1;
         end else begin
            col_pos = col_pos + fsd_pkg::ADDR_W'(1);
         end
      endfunction

      function void check_result(logic [7:0] level, logic re, logic ie);
         pixel_result_type want;
         checked++;
         if (pending.size() == 0) begin
            flag($sformatf("output %0d with nothing expected: level %0d row_end %0b image_end %0b",
                           checked, level, re, ie));
            return;
         end
         want = pending.pop_front();
         if (level !== want.level || re !== want.row_end || ie !== want.image_end)
            flag($sformatf({"output %0d: expected level %0d row_end %0b image_end %0b,",
                            " got level %0d row_end %0b image_end %0b"},
                           checked, want.level, want.row_end, want.image_end, level, re, ie));
      endfunction
   endclass

   // --------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // --------------------------------------------------------------------
   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic [7:0]                      req_red_or_gray = '0;
   logic [7:0]                      req_green       = '0;
   logic [7:0]                      req_blue        = '0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic [7:0]                      rsp_pixel_out;
   logic                            rsp_row_end;
   logic                            rsp_image_end;
   logic                            csr_wr_en       = 1'b0;
   logic [fsd_pkg::CSR_INDEX_W-1:0] csr_index       = '0;
   logic [fsd_pkg::CSR_DATA_W-1:0]  csr_wr_data     = '0;

   // no idling on either side while set
   bit calm = 1'b0;

   dither_scoreboard sb = new();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   floyd_steinberg_dither_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red_or_gray (req_red_or_gray),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // --------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------

   // present one pixel, maybe after a gap, and hold it until taken
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red_or_gray <= r;
      req_green       <= g;
      req_blue        <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(r, g, b);
   endtask

   // stop sending and wait for every queued pixel to come out
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // leaves the write enable high; the caller lowers it after the last write
   task automatic set_register(input logic [fsd_pkg::CSR_INDEX_W-1:0] idx,
                               input logic [fsd_pkg::CSR_DATA_W-1:0]  data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(input logic [1:0] m, input logic c,
                            input logic [fsd_pkg::IMG_WIDTH_W-1:0] w,
                            input logic [fsd_pkg::IMG_HEIGHT_W-1:0] h);
      set_register(fsd_pkg::CSR_MODE, fsd_pkg::CSR_DATA_W'(m));
      set_register(fsd_pkg::CSR_COLOR_INPUT, fsd_pkg::CSR_DATA_W'(c));
      set_register(fsd_pkg::CSR_IMAGE_WIDTH, fsd_pkg::CSR_DATA_W'(w));
      set_register(fsd_pkg::CSR_IMAGE_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   // receiver backpressure in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every output pixel taken by the receiver is checked here
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_pixel_out, rsp_row_end, rsp_image_end);
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // --------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------
   initial begin
      logic [7:0]                      ramp [9];
      logic [1:0]                      m;
      logic [fsd_pkg::CSR_INDEX_W-1:0] idx;
      logic [fsd_pkg::CSR_DATA_W-1:0]  data;
      int                              sel, w, h, split, n, random_items;

      ramp = '{8'd200, 8'd60, 8'd130, 8'd10, 8'd250, 8'd128, 8'd127, 8'd0, 8'd255};
      random_items = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // gray output: black, white, the three primaries, mid gray
      drain();
      configure(fsd_pkg::MODE_GRAY, 1'b1, 12'd3, 16'd2);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h80, 8'h80, 8'h80);

      // threshold on gray input either side of 128, green and blue ignored
      drain();
      configure(fsd_pkg::MODE_THRESH, 1'b0, 12'd4, 16'd1);
      send_pixel(8'd127, 8'hFF, 8'hFF);
      send_pixel(8'd128, 8'h00, 8'h00);
      send_pixel(8'd0, 8'hFF, 8'h00);
      send_pixel(8'd255, 8'h00, 8'hFF);

      // spare mode code, zero width and zero height: each pixel is an image
      drain();
      configure(MODE_SPARE, 1'b0, 12'd0, 16'd0);
      send_pixel(8'd200, 8'h5A, 8'hA5);
      send_pixel(8'd90, 8'hA5, 8'h5A);

      // small dither image, errors of both signs flow right and down
      drain();
      configure(fsd_pkg::MODE_DITHER, 1'b1, 12'd3, 16'd3);
      foreach (ramp[i]) send_pixel(ramp[i], ramp[i], ramp[i]);

      // one row as wide as the widest random image in the tallest image;
      // this writes every line store entry that later images can reach, so
      // mid-image register changes never read an unwritten entry
      drain();
      configure(fsd_pkg::MODE_DITHER, 1'b1, fsd_pkg::IMG_WIDTH_W'(FILL_WIDTH), 16'hFFFF);
      repeat (FILL_WIDTH) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      // shrink both sizes on row one: the next pixel ends row and image
      drain();
      set_register(fsd_pkg::CSR_IMAGE_WIDTH, 16'd1);
      set_register(fsd_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      csr_wr_en <= 1'b0;
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

      // random images, mostly small and mostly dithered
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         m = (sel == 0) ? fsd_pkg::MODE_GRAY : (sel == 1) ? fsd_pkg::MODE_THRESH :
             (sel == 2) ? MODE_SPARE : fsd_pkg::MODE_DITHER;
         sel = $urandom_range(0, 19);
         w = (sel == 0) ? 0 : (sel == 1) ? 1 :
             (sel == 2) ? int'($urandom_range(13, FILL_WIDTH)) : int'($urandom_range(2, 12));
         h = (w > 12) ? int'($urandom_range(1, 2)) : int'($urandom_range(0, 6));
         calm = (random_items > CALM_AFTER) || ($urandom_range(0, 4) == 0);
         drain();
         configure(m, 1'($urandom_range(0, 1)), fsd_pkg::IMG_WIDTH_W'(w),
                   fsd_pkg::IMG_HEIGHT_W'(h));
         // now and then one register changes partway through the image
         split = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20)) : -1;
         n = 0;
         do begin
            if (n == split) begin
               drain();
               idx = fsd_pkg::CSR_INDEX_W'($urandom_range(0, 3));
               case (idx)
                  fsd_pkg::CSR_MODE:
                     data = fsd_pkg::CSR_DATA_W'($urandom_range(0, 3));
                  fsd_pkg::CSR_COLOR_INPUT:
                     data = fsd_pkg::CSR_DATA_W'($urandom_range(0, 1));
                  fsd_pkg::CSR_IMAGE_WIDTH:
                     data = fsd_pkg::CSR_DATA_W'($urandom_range(0, 12));
                  default:
                     data = fsd_pkg::CSR_DATA_W'($urandom_range(0, 6));
               endcase
               set_register(idx, data);
               csr_wr_en <= 1'b0;
            end
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            n++;
            random_items++;
         end while (sb.col_pos != 0 || sb.row_pos != 0);
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0) sb.flag($sformatf("%0d pixels never came out",
                                                    sb.pending.size()));
      if (sb.faults == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
